FILE: design/longest_increasing_subsequence_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the longest increasing subsequence block
// Each macro expands to one clocked concurrent assertion. It is disabled
// while reset is held and reports through $error.
// ----------------------------------------------------------------------------
`ifndef LONGEST_INCREASING_SUBSEQUENCE_TOP_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Types and constants shared by the longest increasing subsequence block.
// ----------------------------------------------------------------------------
`default_nettype none

package lis_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int LINK_W  = IDX_W + 1;
    localparam int VAL_W   = 32;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [LINK_W-1:0] link_t;

    // Top bit set means the element has no predecessor.
    localparam link_t NO_LINK = link_t'(1) << IDX_W;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    seq_end;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] lis_value;
        logic                    lis_last;
        logic                    overflowed;
    } result_t;

    typedef struct packed {
        idx_t                    idx;
        logic signed [VAL_W-1:0] value;
    } pile_ent_t;

    typedef struct packed {
        link_t                   link;
        logic signed [VAL_W-1:0] value;
    } elem_ent_t;

    typedef struct packed {
        logic take;
        logic drop;
        logic srch_rd;
        logic srch_step;
        logic link_rd;
        logic place;
        logic top_rd;
        logic cur_load;
        logic walk_wr;
        logic emit_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic seq_end;
        logic srch_more;
        logic walk_done;
        logic emit_last;
        logic out_free;
    } stat_t;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_SRCH  = 10'b00_0000_0010,
        ST_CMP   = 10'b00_0000_0100,
        ST_PLACE = 10'b00_0000_1000,
        ST_TOP   = 10'b00_0001_0000,
        ST_CUR   = 10'b00_0010_0000,
        ST_WRD   = 10'b00_0100_0000,
        ST_WWR   = 10'b00_1000_0000,
        ST_ERD   = 10'b01_0000_0000,
        ST_ELOAD = 10'b10_0000_0000
    } state_t;

endpackage

`default_nettype wire

FILE: design/lis_ram.sv
// ----------------------------------------------------------------------------
// lis_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/lis_ctrl.sv
// ----------------------------------------------------------------------------
// lis_ctrl
// Sequencer for search, placement, back-link walk and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire lis_pkg::stat_t stat,
    output logic               item_ready,
    output lis_pkg::cmd_t      cmd
);

    lis_pkg::state_t state_reg;
    lis_pkg::state_t state_next;

    assign item_ready = (state_reg == lis_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            lis_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = lis_pkg::ST_SRCH;
                end
            end
            lis_pkg::ST_SRCH:
            begin
                if (stat.full)
                begin
                    // The word is dropped, but an end flag still closes the sequence.
                    cmd.drop   = 1'b1;
                    state_next = stat.seq_end ? lis_pkg::ST_TOP : lis_pkg::ST_IDLE;
                end
                else if (stat.srch_more)
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = lis_pkg::ST_CMP;
                end
                else
                begin
                    cmd.link_rd = 1'b1;
                    state_next  = lis_pkg::ST_PLACE;
                end
            end
            lis_pkg::ST_CMP:
            begin
                cmd.srch_step = 1'b1;
                state_next    = lis_pkg::ST_SRCH;
            end
            lis_pkg::ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = stat.seq_end ? lis_pkg::ST_TOP : lis_pkg::ST_IDLE;
            end
            lis_pkg::ST_TOP:
            begin
                cmd.top_rd = 1'b1;
                state_next = lis_pkg::ST_CUR;
            end
            lis_pkg::ST_CUR:
            begin
                cmd.cur_load = 1'b1;
                state_next   = lis_pkg::ST_WRD;
            end
            lis_pkg::ST_WRD:
            begin
                state_next = lis_pkg::ST_WWR;
            end
            lis_pkg::ST_WWR:
            begin
                cmd.walk_wr = 1'b1;
                state_next  = stat.walk_done ? lis_pkg::ST_ERD : lis_pkg::ST_WRD;
            end
            lis_pkg::ST_ERD:
            begin
                state_next = lis_pkg::ST_ELOAD;
            end
            lis_pkg::ST_ELOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (stat.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = lis_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lis_pkg::ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = lis_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lis_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/lis_dp.sv
// ----------------------------------------------------------------------------
// lis_dp
// Datapath: pile-top and element memories, search bounds, walk and output
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "longest_increasing_subsequence_top_defines.svh"

module lis_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lis_pkg::cmd_t    cmd,
    input  wire lis_pkg::item_t   item,
    input  wire logic             result_ready,
    output lis_pkg::stat_t        stat,
    output logic                  result_valid,
    output lis_pkg::result_t      result
);

    localparam int PILE_W = $bits(lis_pkg::pile_ent_t);
    localparam int ELEM_W = $bits(lis_pkg::elem_ent_t);

    logic signed [lis_pkg::VAL_W-1:0] value_reg;
    logic                             end_reg;
    lis_pkg::cnt_t lo_reg, lo_next;
    lis_pkg::cnt_t hi_reg, hi_next;
    lis_pkg::cnt_t pile_count_reg, pile_count_next;
    lis_pkg::cnt_t elem_count_reg, elem_count_next;
    lis_pkg::cnt_t k_reg, k_next;
    lis_pkg::cnt_t e_reg, e_next;
    lis_pkg::idx_t cur_reg, cur_next;
    logic          ovf_reg, ovf_next;
    logic          result_valid_reg, result_valid_next;
    lis_pkg::result_t result_reg;

    lis_pkg::cnt_t mid;
    lis_pkg::cnt_t lo_m1;
    lis_pkg::cnt_t top_m1;
    lis_pkg::cnt_t k_m1;
    logic          top_less;

    lis_pkg::idx_t       pile_raddr;
    logic [PILE_W-1:0]   pile_rdata;
    lis_pkg::pile_ent_t  pile_rd;
    lis_pkg::pile_ent_t  pile_wr;
    logic [ELEM_W-1:0]   elem_rdata;
    lis_pkg::elem_ent_t  elem_rd;
    lis_pkg::elem_ent_t  elem_wr;
    logic [lis_pkg::VAL_W-1:0] res_rdata;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1  = lo_reg - lis_pkg::cnt_t'(1);
    assign top_m1 = pile_count_reg - lis_pkg::cnt_t'(1);
    assign k_m1   = k_reg - lis_pkg::cnt_t'(1);

    assign pile_rd  = lis_pkg::pile_ent_t'(pile_rdata);
    assign elem_rd  = lis_pkg::elem_ent_t'(elem_rdata);
    assign top_less = $signed(pile_rd.value) < $signed(value_reg);

    always_comb
    begin
        if (cmd.top_rd)
        begin
            pile_raddr = top_m1[lis_pkg::IDX_W-1:0];
        end
        else if (cmd.link_rd)
        begin
            pile_raddr = lo_m1[lis_pkg::IDX_W-1:0];
        end
        else
        begin
            pile_raddr = mid[lis_pkg::IDX_W-1:0];
        end
    end

    assign pile_wr.idx   = elem_count_reg[lis_pkg::IDX_W-1:0];
    assign pile_wr.value = value_reg;
    assign elem_wr.value = value_reg;
    assign elem_wr.link  = (lo_reg != '0) ? {1'b0, pile_rd.idx} : lis_pkg::NO_LINK;

    lis_ram #(
        .WIDTH (PILE_W),
        .DEPTH (lis_pkg::MAX_LEN)
    ) u_pile_ram (
        .clk     (clk),
        .wr_en   (cmd.place),
        .wr_addr (lo_reg[lis_pkg::IDX_W-1:0]),
        .wr_data (pile_wr),
        .rd_addr (pile_raddr),
        .rd_data (pile_rdata)
    );

    lis_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (lis_pkg::MAX_LEN)
    ) u_elem_ram (
        .clk     (clk),
        .wr_en   (cmd.place),
        .wr_addr (elem_count_reg[lis_pkg::IDX_W-1:0]),
        .wr_data (elem_wr),
        .rd_addr (cur_reg),
        .rd_data (elem_rdata)
    );

    // The walk runs backwards, so the subsequence is parked here and read forwards.
    lis_ram #(
        .WIDTH (lis_pkg::VAL_W),
        .DEPTH (lis_pkg::MAX_LEN)
    ) u_res_ram (
        .clk     (clk),
        .wr_en   (cmd.walk_wr),
        .wr_addr (k_m1[lis_pkg::IDX_W-1:0]),
        .wr_data (elem_rd.value),
        .rd_addr (e_reg[lis_pkg::IDX_W-1:0]),
        .rd_data (res_rdata)
    );

    always_comb
    begin
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        pile_count_next   = pile_count_reg;
        elem_count_next   = elem_count_reg;
        k_next            = k_reg;
        e_next            = e_reg;
        cur_next          = cur_reg;
        ovf_next          = ovf_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (cmd.take)
        begin
            lo_next = '0;
            hi_next = pile_count_reg;
        end
        if (cmd.drop)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.srch_step)
        begin
            if (top_less)
            begin
                lo_next = mid + lis_pkg::cnt_t'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.place)
        begin
            elem_count_next = elem_count_reg + lis_pkg::cnt_t'(1);
            if (lo_reg == pile_count_reg)
            begin
                pile_count_next = pile_count_reg + lis_pkg::cnt_t'(1);
            end
        end
        if (cmd.top_rd)
        begin
            k_next = pile_count_reg;
            e_next = '0;
        end
        if (cmd.cur_load)
        begin
            cur_next = pile_rd.idx;
        end
        if (cmd.walk_wr)
        begin
            k_next   = k_m1;
            cur_next = elem_rd.link[lis_pkg::IDX_W] ? '0 : elem_rd.link[lis_pkg::IDX_W-1:0];
        end
        if (cmd.emit_load)
        begin
            e_next            = e_reg + lis_pkg::cnt_t'(1);
            result_valid_next = 1'b1;
        end
        if (cmd.clear)
        begin
            pile_count_next = '0;
            elem_count_next = '0;
            ovf_next        = 1'b0;
            e_next          = '0;
            k_next          = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg           <= '0;
            hi_reg           <= '0;
            pile_count_reg   <= '0;
            elem_count_reg   <= '0;
            k_reg            <= '0;
            e_reg            <= '0;
            cur_reg          <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
            pile_count_reg   <= pile_count_next;
            elem_count_reg   <= elem_count_next;
            k_reg            <= k_next;
            e_reg            <= e_next;
            cur_reg          <= cur_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            value_reg <= item.value;
            end_reg   <= item.seq_end;
        end
        if (cmd.emit_load)
        begin
            result_reg.lis_value  <= res_rdata;
            result_reg.lis_last   <= stat.emit_last;
            result_reg.overflowed <= ovf_reg;
        end
    end

    assign stat.full      = (elem_count_reg == lis_pkg::cnt_t'(lis_pkg::MAX_LEN));
    assign stat.seq_end   = end_reg;
    assign stat.srch_more = (lo_reg < hi_reg);
    assign stat.walk_done = (k_reg == lis_pkg::cnt_t'(1));
    assign stat.emit_last = (e_reg == top_m1);
    assign stat.out_free  = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `LIS_ASSERT_NOW(a_load_when_free, cmd.emit_load, !result_valid_reg || result_ready, "result word overwritten before it was taken")
    `LIS_ASSERT_NOW(a_piles_le_elems, 1'b1, pile_count_reg <= elem_count_reg, "more piles than stored elements")
    `LIS_ASSERT_NOW(a_step_in_range, cmd.srch_step, lo_reg < hi_reg, "search step with an empty interval")
    `LIS_ASSERT_NOW(a_walk_count, cmd.walk_wr, k_reg != '0, "back-link walk ran past the first pile")
    `LIS_ASSERT_NEXT(a_take_bounds, cmd.take, (lo_reg == '0) && (hi_reg == $past(pile_count_reg)), "search bounds not set up on a new word")
    `LIS_ASSERT_NEXT(a_read_then_step, cmd.srch_rd, cmd.srch_step, "pile-top read not followed by a search step")

endmodule

`default_nettype wire

FILE: design/longest_increasing_subsequence_top.sv
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_top
// Patience-sorting longest increasing subsequence over a stream of words.
// ----------------------------------------------------------------------------
// Each input word carries a signed 32-bit value and an end flag. Values are
// placed on piles by a binary search over the pile tops, held in a memory with
// a registered read; a word takes at most 6 search steps, as no more than 63
// piles stand when it is placed. A word arriving when 64 elements are stored
// is dropped and sets the overflowed flag on every result of that sequence.
// On the word with the end flag, the back links are walked from the
// rightmost pile, and then the n result words of a subsequence of length n
// leave in ascending order, one at a time as the output register frees, the
// last one marked with lis_last. The next input word is taken once the last
// result word is in the output register. All state clears after each
// sequence; no clearing pass follows reset.
`default_nettype none

module longest_increasing_subsequence_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire lis_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output lis_pkg::result_t       result
);

    lis_pkg::cmd_t  cmd;
    lis_pkg::stat_t stat;

    lis_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .stat       (stat),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    lis_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .result_ready (result_ready),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
